// ===== hdl/rycc_pkg.sv =====
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared constants and types for the 10-bit BT.601 RGB to YCbCr converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

   localparam int unsigned COMP_W     = 8;   // input component width
   localparam int unsigned CODE_W     = 10;  // output code width
   localparam int unsigned THRESH_W   = 10;  // threshold register width
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 10;

   // luma weights in Q16, they sum to exactly 65536
   localparam logic [23:0] Y_COEF_R = 24'd19595;
   localparam logic [23:0] Y_COEF_G = 24'd38470;
   localparam logic [23:0] Y_COEF_B = 24'd7471;

   // luma span of 876 codes over full scale 255
   localparam logic [33:0] LUMA_SPAN  = 34'd876;
   localparam logic [34:0] RECIP_255  = 35'd65793;   // floor(2^24 / 255)
   localparam logic [17:0] FULL_SCALE = 18'd255;
   localparam logic [9:0]  OFFSET_Y   = 10'd64;

   // colour-difference gains in Q16
   localparam logic signed [43:0] K_CB = 44'sd129445;
   localparam logic signed [43:0] K_CR = 44'sd163606;
   localparam logic signed [43:0] OFFSET_C_Q32 = 44'sd512 <<< 32;

   localparam logic [COMP_W-1:0] COMP_MAX = '1;

   // reset values of the control registers
   localparam logic                CLAMP_EN_RST = 1'b1;
   localparam logic [THRESH_W-1:0] WHITE_RST    = 10'd747;
   localparam logic [THRESH_W-1:0] BLACK_RST    = 10'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLAMP_ENABLE    = 2'd0,
      CSR_WHITE_THRESHOLD = 2'd1,
      CSR_BLACK_THRESHOLD = 2'd2
   } csr_index_type;

endpackage

// ===== hdl/rycc_if.sv =====
// ----------------------------------------------------------------------------
// rycc_if
// Valid/ready channels for pixels in, codes out and control register writes.
// ----------------------------------------------------------------------------
interface rycc_pix_if;
   import rycc_pkg::*;

   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] blue_in;
   logic [COMP_W-1:0] green_in;
   logic [COMP_W-1:0] red_in;
   logic              line_end_in;

   modport source (output valid, blue_in, green_in, red_in, line_end_in, input ready);
   modport sink   (input valid, blue_in, green_in, red_in, line_end_in, output ready);
endinterface

interface rycc_code_if;
   import rycc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] luma_code;
   logic [CODE_W-1:0] blue_diff_code;
   logic [CODE_W-1:0] red_diff_code;
   logic              line_end_out;

   modport source (output valid, luma_code, blue_diff_code, red_diff_code, line_end_out,
                   input ready);
   modport sink   (input valid, luma_code, blue_diff_code, red_diff_code, line_end_out,
                   output ready);
endinterface

interface rycc_csr_if;
   import rycc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rgb_to_ycbcr_10bit_clamped.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_10bit_clamped
// BT.601 RGB to 10-bit YCbCr with optional near-white/near-black clamping.
//
//   channel    dir   handshake      content
//   req_chan   in    valid/ready    blue, green, red (8 bit), end of line
//   rsp_chan   out   valid/ready    luma, Cb, Cr codes (10 bit), end of line
//   csr_chan   in    valid/ready    register index, write data (always ready)
//
// five register stages: clamp, luma sum, scale/difference, multiply, output.
// one pixel per clock while rsp is not stalled; rsp valid once the pixel reaches the output register.
// each stage has its own valid bit and ready, so bubbles collapse and the
// input keeps filling empty stages while a finished result waits at the
// output; with all five stages full and rsp stalled, req ready drops in that same cycle.
// synchronous reset clears valid bits and sets the control registers.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_10bit_clamped (
   input  logic         clock,
   input  logic         reset,
   rycc_pix_if.sink     req_chan,
   rycc_code_if.source  rsp_chan,
   rycc_csr_if.sink     csr_chan
);
   import rycc_pkg::*;

   localparam int unsigned NUM_STAGES = 5;

   // control registers
   logic                clamp_en_ff;
   logic [THRESH_W-1:0] white_ff;
   logic [THRESH_W-1:0] black_ff;

   // pipeline control
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] rdy;

   // stage 1: clamped pixel
   logic [9:0]        sum;
   logic [COMP_W-1:0] s1_b_in, s1_g_in, s1_r_in;
   logic [COMP_W-1:0] s1_b_ff, s1_g_ff, s1_r_ff;
   logic              s1_eol_ff;

   // stage 2: luma in Q16
   logic [23:0]       s2_yq_in;
   logic [23:0]       s2_yq_ff;
   logic [COMP_W-1:0] s2_b_ff, s2_r_ff;
   logic              s2_eol_ff;

   // stage 3: scaled luma and differences
   logic [33:0]        y_span;
   logic [17:0]        s3_t_ff;
   logic signed [24:0] s3_db_in, s3_dr_in;
   logic signed [24:0] s3_db_ff, s3_dr_ff;
   logic               s3_eol_ff;

   // stage 4: quotient estimate and chroma products
   logic [34:0]        q_prod;
   logic [9:0]         s4_q_ff;
   logic [17:0]        s4_t_ff;
   logic signed [43:0] s4_pb_in, s4_pr_in;
   logic signed [43:0] s4_pb_ff, s4_pr_ff;
   logic               s4_eol_ff;

   // stage 5: output register
   logic [17:0]        rem;
   logic [9:0]         luma_in;
   logic signed [43:0] cb_total, cr_total;
   logic [CODE_W-1:0]  cb_in, cr_in;
   logic [CODE_W-1:0]  luma_ff, cb_ff, cr_ff;
   logic               eol_ff;

   // ---------------- control registers ----------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_en_ff <= CLAMP_EN_RST;
         white_ff    <= WHITE_RST;
         black_ff    <= BLACK_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_CLAMP_ENABLE:    clamp_en_ff <= csr_chan.data[0];
            CSR_WHITE_THRESHOLD: white_ff    <= csr_chan.data[THRESH_W-1:0];
            CSR_BLACK_THRESHOLD: black_ff    <= csr_chan.data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   always_comb begin
      rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_chan.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = rdy[0];

   // ---------------- stage 1: clamp ----------------
   always_comb begin
      sum     = 10'(req_chan.blue_in) + 10'(req_chan.green_in) + 10'(req_chan.red_in);
      s1_b_in = req_chan.blue_in;
      s1_g_in = req_chan.green_in;
      s1_r_in = req_chan.red_in;
      if (clamp_en_ff && (sum > white_ff)) begin
         s1_b_in = COMP_MAX;
         s1_g_in = COMP_MAX;
         s1_r_in = COMP_MAX;
      end
      // black test comes second so it wins when both hit
      if (clamp_en_ff && (sum < black_ff)) begin
         s1_b_in = '0;
         s1_g_in = '0;
         s1_r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_b_ff   <= s1_b_in;
         s1_g_ff   <= s1_g_in;
         s1_r_ff   <= s1_r_in;
         s1_eol_ff <= req_chan.line_end_in;
      end
   end

   // ---------------- stage 2: luma sum ----------------
   assign s2_yq_in = 24'(s1_r_ff) * Y_COEF_R + 24'(s1_g_ff) * Y_COEF_G
                   + 24'(s1_b_ff) * Y_COEF_B;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_yq_ff  <= s2_yq_in;
         s2_b_ff   <= s1_b_ff;
         s2_r_ff   <= s1_r_ff;
         s2_eol_ff <= s1_eol_ff;
      end
   end

   // ---------------- stage 3: span scale and differences ----------------
   assign y_span   = 34'(s2_yq_ff) * LUMA_SPAN;
   assign s3_db_in = $signed({1'b0, s2_b_ff, 16'b0}) - $signed({1'b0, s2_yq_ff});
   assign s3_dr_in = $signed({1'b0, s2_r_ff, 16'b0}) - $signed({1'b0, s2_yq_ff});

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_t_ff   <= y_span[33:16];
         s3_db_ff  <= s3_db_in;
         s3_dr_ff  <= s3_dr_in;
         s3_eol_ff <= s2_eol_ff;
      end
   end

   // ---------------- stage 4: divide estimate and chroma gain ----------------
   // quotient by 255 via reciprocal, low by at most one
   assign q_prod   = 35'(s3_t_ff) * RECIP_255;
   assign s4_pb_in = 44'(s3_db_ff) * K_CB;
   assign s4_pr_in = 44'(s3_dr_ff) * K_CR;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_q_ff   <= q_prod[33:24];
         s4_t_ff   <= s3_t_ff;
         s4_pb_ff  <= s4_pb_in;
         s4_pr_ff  <= s4_pr_in;
         s4_eol_ff <= s3_eol_ff;
      end
   end

   // ---------------- stage 5: correct, offset, output ----------------
   always_comb begin
      rem      = s4_t_ff - 18'(s4_q_ff) * FULL_SCALE;
      luma_in  = s4_q_ff + 10'(rem >= FULL_SCALE) + OFFSET_Y;
      cb_total = s4_pb_ff + OFFSET_C_Q32;
      cr_total = s4_pr_ff + OFFSET_C_Q32;
      // negative totals floor to zero
      cb_in    = cb_total[43] ? '0 : cb_total[41:32];
      cr_in    = cr_total[43] ? '0 : cr_total[41:32];
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         luma_ff <= luma_in;
         cb_ff   <= cb_in;
         cr_ff   <= cr_in;
         eol_ff  <= s4_eol_ff;
      end
   end

   assign rsp_chan.valid          = vld_ff[NUM_STAGES-1];
   assign rsp_chan.luma_code      = luma_ff;
   assign rsp_chan.blue_diff_code = cb_ff;
   assign rsp_chan.red_diff_code  = cr_ff;
   assign rsp_chan.line_end_out   = eol_ff;

endmodule

// ===== hdl/rycc_checker.sv =====
// ----------------------------------------------------------------------------
// rycc_checker
// Port-level checks on the result channel of the YCbCr converter.
// ----------------------------------------------------------------------------
module rycc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rycc_pkg::CODE_W-1:0]   luma_code,
   input logic [rycc_pkg::CODE_W-1:0]   blue_diff_code,
   input logic [rycc_pkg::CODE_W-1:0]   red_diff_code
);
   import rycc_pkg::*;

   // nothing may come out of the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(luma_code) && $stable(blue_diff_code)
                                  && $stable(red_diff_code))
      else $error("result changed while stalled");

   // luma spans 64 black to 940 white
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (luma_code >= 10'd64) && (luma_code <= 10'd940))
      else $error("luma code out of range");

   // 8-bit inputs keep both differences well inside the code range
   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (blue_diff_code >= 10'd64) && (blue_diff_code <= 10'd960)
                    && (red_diff_code >= 10'd64) && (red_diff_code <= 10'd960))
      else $error("colour-difference code out of range");

endmodule

bind rgb_to_ycbcr_10bit_clamped rycc_checker u_rycc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .luma_code      (rsp_chan.luma_code),
   .blue_diff_code (rsp_chan.blue_diff_code),
   .red_diff_code  (rsp_chan.red_diff_code)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 10-bit BT.601 RGB to YCbCr converter. A short table of pixels
// runs at the reset settings, then random pixels run under several register
// settings. Every code is compared with an in-bench prediction, and both
// sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import rycc_pkg::*;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       line_end;
   } pixel_type;

   typedef struct packed {
      logic [9:0] luma;
      logic [9:0] cb;
      logic [9:0] cr;
      logic       line_end;
   } code_type;

   typedef struct {
      pixel_type  pix;
      bit         typed;
      logic [9:0] luma;
      logic [9:0] cb;
      logic [9:0] cr;
   } sweep_row_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // index with no register

   // luma weights and chroma gains, Q16
   localparam longint WEIGHT_R = 19595;
   localparam longint WEIGHT_G = 38470;
   localparam longint WEIGHT_B = 7471;
   localparam longint GAIN_CB  = 129445;
   localparam longint GAIN_CR  = 163606;

   localparam int HOLD_AT   = 50;    // pixels taken before the long output stall
   localparam int LONG_HOLD = 250;
   localparam int TAIL      = 20;

   logic clock;
   logic reset;

   rycc_pix_if  req_chan ();
   rycc_code_if rsp_chan ();
   rycc_csr_if  csr_chan ();

   rgb_to_ycbcr_10bit_clamped dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // register copies for prediction
   bit         clamp_on  = CLAMP_EN_RST;
   logic [9:0] white_lvl = WHITE_RST;
   logic [9:0] black_lvl = BLACK_RST;

   code_type      codes_due[$];
   sweep_row_type sweep_rows[$];
   int            pixels_taken = 0;
   int            mismatches   = 0;
   bit            steady       = 1'b0;
   int            rsp_gap      = 0;
   int            hold_left    = 0;
   bit            hold_done    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [9:0] chroma_code(longint diff_q16, longint gain);
      longint total;
      total = diff_q16 * gain + (longint'(512) <<< 32);
      if (total < 0)
         total = 0;
      return 10'(total >>> 32);
   endfunction

   function automatic code_type convert_pixel(pixel_type p);
      longint   b, g, r, sum, yq;
      code_type c;
      b = p.blue;
      g = p.green;
      r = p.red;
      sum = b + g + r;
      if (clamp_on) begin
         if (sum > longint'(white_lvl)) begin
            b = 255;
            g = 255;
            r = 255;
         end
         // black test second, so black wins when both hit
         if (sum < longint'(black_lvl)) begin
            b = 0;
            g = 0;
            r = 0;
         end
      end
      yq = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
      c.luma = 10'((yq * 876) / (longint'(255) <<< 16) + 64);
      c.cb = chroma_code(b * 65536 - yq, GAIN_CB);
      c.cr = chroma_code(r * 65536 - yq, GAIN_CR);
      c.line_end = p.line_end;
      return c;
   endfunction

   // pick components whose sum is s
   function automatic pixel_type split_sum(int s, logic eol);
      pixel_type p;
      int        rest;
      p.red = 8'($urandom_range(s > 510 ? s - 510 : 0, s < 255 ? s : 255));
      rest = s - p.red;
      p.green = 8'($urandom_range(rest > 255 ? rest - 255 : 0, rest < 255 ? rest : 255));
      p.blue = 8'(rest - p.green);
      p.line_end = eol;
      return p;
   endfunction

   function automatic logic [7:0] edge_comp();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         3: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int        roll, target;
      logic      eol;
      roll = $urandom_range(0, 99);
      eol = ($urandom_range(0, 7) == 0);
      if (roll < 30) begin
         p = pixel_type'(25'($urandom));
      end else if (roll < 80) begin
         // sums around one of the two thresholds
         target = (roll < 55) ? int'(white_lvl) : int'(black_lvl);
         target = target + $urandom_range(0, 4) - 2;
         if (target < 0)
            target = 0;
         if (target > 765)
            target = 765;
         p = split_sum(target, eol);
      end else begin
         p.blue = edge_comp();
         p.green = edge_comp();
         p.red = edge_comp();
         p.line_end = eol;
      end
      return p;
   endfunction

   task automatic add_row(input int b, input int g, input int r, input bit eol,
                          input bit typed, input int y, input int cb, input int cr);
      sweep_row_type row;
      row.pix = '{blue: 8'(b), green: 8'(g), red: 8'(r), line_end: eol};
      row.typed = typed;
      row.luma = 10'(y);
      row.cb = 10'(cb);
      row.cr = 10'(cr);
      sweep_rows.push_back(row);
   endtask

   task automatic send_pixel(input pixel_type p, input code_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.blue_in <= p.blue;
      req_chan.green_in <= p.green;
      req_chan.red_in <= p.red;
      req_chan.line_end_in <= p.line_end;
      do @(posedge clock); while (!req_chan.ready);
      codes_due.push_back(want);
      pixels_taken++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (codes_due.size() != 0);
   endtask

   // leaves valid high so back-to-back writes need one assignment per step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [9:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_CLAMP_ENABLE:    clamp_on = value[0];
         CSR_WHITE_THRESHOLD: white_lvl = value;
         CSR_BLACK_THRESHOLD: black_lvl = value;
         default: ;
      endcase
   endtask

   task automatic run_phase(input bit en, input int white, input int black, input int count,
                            input bit quiet, input bit pause_mid, input bit spare);
      pixel_type p;
      write_reg(CSR_CLAMP_ENABLE, {9'($urandom), en});
      write_reg(CSR_WHITE_THRESHOLD, 10'(white));
      write_reg(CSR_BLACK_THRESHOLD, 10'(black));
      if (spare)
         write_reg(CSR_SPARE, 10'($urandom));
      csr_chan.valid <= 1'b0;
      steady = quiet;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) begin
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         p = random_pixel();
         send_pixel(p, convert_pixel(p));
      end
      req_chan.valid <= 1'b0;
      wait_drained();
      steady = 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // output side: random stalls, one long hold, and the checker
   always @(posedge clock) begin : code_side
      code_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (codes_due.size() == 0) begin
               $display("%0t: unexpected transaction, luma %0d", $time, rsp_chan.luma_code);
               mismatches++;
            end else begin
               want = codes_due.pop_front();
               check_field("luma", want.luma, rsp_chan.luma_code);
               check_field("cb", want.cb, rsp_chan.blue_diff_code);
               check_field("cr", want.cr, rsp_chan.red_diff_code);
               check_field("line_end", want.line_end, rsp_chan.line_end_out);
            end
            rsp_gap = pick_gap();
         end
         if (!hold_done && pixels_taken >= HOLD_AT) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      code_type want;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.blue_in = '0;
      req_chan.green_in = '0;
      req_chan.red_in = '0;
      req_chan.line_end_in = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;

      // reset settings: clamp on, white above 747, black below 10
      add_row(0, 0, 0, 0, 1, 64, 512, 512);
      add_row(255, 255, 255, 1, 1, 940, 512, 512);
      add_row(250, 250, 250, 0, 1, 940, 512, 512);   // sum 750 forced white
      add_row(249, 249, 249, 0, 0, 0, 0, 0);         // sum 747 left alone
      add_row(249, 249, 250, 1, 1, 940, 512, 512);
      add_row(3, 3, 3, 0, 1, 64, 512, 512);          // sum 9 forced black
      add_row(4, 3, 3, 0, 0, 0, 0, 0);               // sum 10 left alone
      add_row(0, 0, 9, 1, 1, 64, 512, 512);
      add_row(255, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 255, 0, 1, 0, 0, 0, 0);
      add_row(0, 0, 255, 0, 0, 0, 0, 0);
      add_row(255, 255, 0, 0, 0, 0, 0, 0);
      add_row(0, 255, 255, 1, 0, 0, 0, 0);
      add_row(255, 0, 255, 0, 0, 0, 0, 0);
      add_row(128, 128, 128, 0, 0, 0, 0, 0);
      add_row(1, 2, 255, 1, 0, 0, 0, 0);
      add_row(255, 254, 1, 0, 0, 0, 0, 0);
      add_row(170, 85, 0, 1, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (sweep_rows[i]) begin
         if (sweep_rows[i].typed)
            want = '{luma: sweep_rows[i].luma, cb: sweep_rows[i].cb, cr: sweep_rows[i].cr,
                     line_end: sweep_rows[i].pix.line_end};
         else
            want = convert_pixel(sweep_rows[i].pix);
         send_pixel(sweep_rows[i].pix, want);
      end
      req_chan.valid <= 1'b0;
      wait_drained();

      run_phase(1, 747, 10, 100, 0, 0, 0);
      run_phase(0, 747, 10, 80, 0, 0, 0);
      run_phase(1, 0, 1023, 50, 0, 0, 0);      // black always hit, white hit for every nonzero sum
      run_phase(1, 1023, 0, 70, 0, 1, 0);      // white never forced
      run_phase(1, 765, 0, 70, 0, 0, 0);
      run_phase(1, $urandom_range(600, 765), $urandom_range(0, 100), 80, 1, 0, 0);
      run_phase(1, $urandom_range(0, 1023), $urandom_range(0, 1023), 100, 0, 1, 0);
      run_phase(0, $urandom_range(0, 1023), $urandom_range(0, 1023), 60, 0, 0, 1);

      repeat (TAIL) @(posedge clock);
      if (codes_due.size() != 0) begin
         $display("%0t: %0d transactions never arrived", $time, codes_due.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
